@@ rtl/psr_pkg.sv @@
// Shared types and constants of the Poisson stencil relaxation unit.
package psr_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int ADDR_W    = 15;
  localparam int DIM_W     = 6;
  localparam int COEF_W    = 31;
  localparam int EPS_W     = 24;
  localparam int SWEEP_W   = 12;
  localparam int CFG_IDX_W = 3;
  localparam int RES_W     = 31;

  localparam logic [DIM_W-1:0] MAX_DIM = 6'd32;

  localparam logic signed [DATA_W-1:0] DMAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] DMIN = 32'sh8000_0000;

  // Word actions.
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_RUN    = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Y     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Z     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FLUX_SCALE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd7;

  // Mode bits.
  localparam int MODE_DIEL = 0;
  localparam int MODE_IND  = 1;

  typedef struct packed {
    logic [1:0]               action;
    logic [ADDR_W-1:0]        cell_index;
    logic signed [DATA_W-1:0] charge_in;
    logic signed [DATA_W-1:0] induced_in;
    logic [EPS_W-1:0]         permittivity_in;
    logic signed [DATA_W-1:0] potential_in;
    logic [SWEEP_W-1:0]       sweep_count;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] potential_out;
    logic [RES_W-1:0]         residual_max;
    logic                     saturated;
  } out_word_t;

  typedef struct packed {
    logic                     start;
    logic signed [DATA_W-1:0] d;
    logic [EPS_W-1:0]         eps;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic                     ovf;
    logic signed [DATA_W-1:0] q;
  } div_rsp_t;

endpackage

@@ rtl/psr_div.sv @@
// Radix-2 divider for the dielectric step: saturated (d * 2^FRAC_BITS) / eps.
module psr_div import psr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int NUM_W = DATA_W + FRAC_BITS;

  typedef enum logic [1:0] {D_IDLE, D_STEP, D_FIN} dstate_t;

  dstate_t                  state;
  logic [5:0]               cnt;
  logic [EPS_W-1:0]         rem;
  logic [NUM_W-1:0]         num;
  logic [EPS_W-1:0]         eps;
  logic                     neg;
  logic                     d_zero;
  logic                     eps_zero;

  logic [DATA_W-1:0]        mag;
  logic [EPS_W:0]           rem_sh;
  logic                     fit;
  logic signed [DATA_W-1:0] q_fin;
  logic                     ovf_fin;

  assign mag    = req.d[DATA_W-1] ? DATA_W'(-req.d) : DATA_W'(req.d);
  assign rem_sh = {rem, num[NUM_W-1]};
  assign fit    = rem_sh >= {1'b0, eps};

  // Sign and saturation of the finished quotient.
  always_comb begin
    q_fin   = '0;
    ovf_fin = 1'b0;
    if (eps_zero) begin
      if (!d_zero) begin
        q_fin   = neg ? DMIN : DMAX;
        ovf_fin = 1'b1;
      end
    end else if (!neg) begin
      if (num > NUM_W'(33'h0_7FFF_FFFF)) begin
        q_fin   = DMAX;
        ovf_fin = 1'b1;
      end else begin
        q_fin = $signed(num[DATA_W-1:0]);
      end
    end else begin
      if (num > NUM_W'(33'h0_8000_0000)) begin
        q_fin   = DMIN;
        ovf_fin = 1'b1;
      end else begin
        q_fin = $signed(DATA_W'(0) - num[DATA_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= D_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (state == D_FIN);
      case (state)
        D_IDLE: begin
          if (req.start) begin
            neg      <= req.d[DATA_W-1];
            d_zero   <= (req.d == '0);
            eps_zero <= (req.eps == '0);
            eps      <= req.eps;
            num      <= {mag, {FRAC_BITS{1'b0}}};
            rem      <= '0;
            cnt      <= 6'(NUM_W - 1);
            state    <= (req.eps == '0) ? D_FIN : D_STEP;
          end
        end
        D_STEP: begin
          rem <= fit ? EPS_W'(rem_sh - {1'b0, eps}) : rem_sh[EPS_W-1:0];
          num <= {num[NUM_W-2:0], fit};
          cnt <= cnt - 6'd1;
          if (cnt == '0) begin
            state <= D_FIN;
          end
        end
        D_FIN: begin
          rsp.q    <= q_fin;
          rsp.ovf  <= ovf_fin;
          state    <= D_IDLE;
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/poisson_stencil_relaxation_unit.sv @@
// Top level of the Poisson stencil relaxation unit: memories, sweep sequencer and result queue.
//
// The unit holds a 3-D grid of up to 32 x 32 x 32 cells in two single-port-write, registered-read
// memories, one for potentials and one for charge, induced charge and dielectric. Load words
// and read words are taken one per cycle while the unit is idle and the queue has room; a read's
// potential is registered by the memory read and then pushed into the queue, and a two-word result
// queue lets new words in while a result waits downstream. A run word occupies the unit until its
// last sweep ends: each interior cell passes through the seven reads of its stencil through the
// one memory read port and the arithmetic pipeline behind it and, when dielectric weighting is
// on, through the radix-2 divider that scales the residual. Stores are undefined until loaded,
// so reset performs no clearing pass.
module poisson_stencil_relaxation_unit import psr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data
);

  localparam int CELLS = 1 << ADDR_W;
  localparam logic [2:0] TAG_LAST = 3'd6;
  localparam logic signed [64:0] WMAX = 65'sd2147483647;
  localparam logic signed [64:0] WMIN = -65'sd2147483648;

  typedef enum logic [2:0] {
    S_IDLE, S_ISSUE, S_WAIT, S_FLUX, S_RESID, S_DIV, S_UPDATE, S_DONE
  } state_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] charge;
    logic signed [DATA_W-1:0] induced;
    logic [EPS_W-1:0]         eps;
  } stat_t;

  function automatic logic signed [DATA_W-1:0] clamp(input logic signed [64:0] v);
    if (v > WMAX) return DMAX;
    if (v < WMIN) return DMIN;
    return v[DATA_W-1:0];
  endfunction

  function automatic logic over(input logic signed [64:0] v);
    return (v > WMAX) || (v < WMIN);
  endfunction

  // Configuration registers.
  logic [DIM_W-1:0]  size_x, size_y, size_z;
  logic [COEF_W-1:0] coef_x, coef_y, coef_z, flux_scale;
  logic [1:0]        mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x     <= 6'd32;
      size_y     <= 6'd32;
      size_z     <= 6'd32;
      coef_x     <= 31'd65536;
      coef_y     <= 31'd65536;
      coef_z     <= 31'd65536;
      flux_scale <= 31'd869;
      mode       <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIZE_X:     size_x     <= cfg_data[DIM_W-1:0];
        REG_SIZE_Y:     size_y     <= cfg_data[DIM_W-1:0];
        REG_SIZE_Z:     size_z     <= cfg_data[DIM_W-1:0];
        REG_COEF_X:     coef_x     <= cfg_data;
        REG_COEF_Y:     coef_y     <= cfg_data;
        REG_COEF_Z:     coef_z     <= cfg_data;
        REG_FLUX_SCALE: flux_scale <= cfg_data;
        REG_MODE:       mode       <= cfg_data[1:0];
        default:        mode       <= mode;
      endcase
    end
  end

  logic diel, ind;
  assign diel = mode[MODE_DIEL];
  assign ind  = mode[MODE_IND];

  // Sequencer state.
  state_t             state;
  logic [DIM_W-1:0]   nx_r, ny_r, nz_r;
  logic [ADDR_W-1:0]  nxy_r;
  logic [ADDR_W-1:0]  c, c_start;
  logic [DIM_W-1:0]   xi, yj, zk;
  logic [2:0]         tag;
  logic [SWEEP_W-1:0] sweeps_left;
  logic [RES_W-1:0]   peak, res_peak;
  logic               ovf;
  logic               inflight;

  // Input acceptance and the result queue.
  logic      in_acc, load_acc, read_acc, run_acc;
  logic      push, pop;
  out_word_t push_word, tail;
  logic [1:0] fifo_cnt;
  logic [2:0] occ;

  assign in_acc   = in_valid && !in_stall;
  assign load_acc = in_acc && (in_word.action == ACT_LOAD);
  assign read_acc = in_acc && (in_word.action == ACT_READ);
  assign run_acc  = in_acc && (in_word.action == ACT_RUN);

  assign pop       = out_valid && !out_stall;
  assign out_valid = (fifo_cnt != 2'd0);
  // A read or a run reserves its queue slot when it is accepted.
  assign occ       = 3'(fifo_cnt) + 3'(inflight) - 3'(pop);
  assign in_stall  = (state != S_IDLE) || (occ >= 3'd2);

  // Grid size for a run about to start.
  logic [DIM_W-1:0]  nx_a, ny_a, nz_a;
  logic [10:0]       nxy_a;
  logic              small_a;
  assign nx_a    = (size_x > MAX_DIM) ? MAX_DIM : size_x;
  assign ny_a    = (size_y > MAX_DIM) ? MAX_DIM : size_y;
  assign nz_a    = (size_z > MAX_DIM) ? MAX_DIM : size_z;
  assign nxy_a   = 11'(nx_a * ny_a);
  assign small_a = (nx_a < 6'd3) || (ny_a < 6'd3) || (nz_a < 6'd3);

  // Memory ports.
  logic [DATA_W-1:0] pot_mem [CELLS];
  stat_t             stat_mem [CELLS];
  logic [DATA_W-1:0] pot_q;
  stat_t             stat_q;
  logic [ADDR_W-1:0] raddr, issue_addr;
  logic              issuing;
  logic              upd_we;
  logic              pot_we;
  logic [ADDR_W-1:0] pot_waddr;
  logic [DATA_W-1:0] pot_wdata;
  logic signed [DATA_W-1:0] nphi;

  assign issuing = (state == S_ISSUE);
  assign upd_we  = (state == S_UPDATE);

  always_comb begin
    case (tag)
      3'd0:    issue_addr = c;
      3'd1:    issue_addr = c - ADDR_W'(1);
      3'd2:    issue_addr = c + ADDR_W'(1);
      3'd3:    issue_addr = c - ADDR_W'(nx_r);
      3'd4:    issue_addr = c + ADDR_W'(nx_r);
      3'd5:    issue_addr = c - nxy_r;
      default: issue_addr = c + nxy_r;
    endcase
  end

  assign raddr     = issuing ? issue_addr : in_word.cell_index;
  assign pot_we    = load_acc || upd_we;
  assign pot_waddr = upd_we ? c : in_word.cell_index;
  assign pot_wdata = upd_we ? nphi : in_word.potential_in;

  always_ff @(posedge clk) begin
    if (pot_we) begin
      pot_mem[pot_waddr] <= pot_wdata;
    end
    pot_q <= pot_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (load_acc) begin
      stat_mem[in_word.cell_index] <= '{charge:  in_word.charge_in,
                                        induced: in_word.induced_in,
                                        eps:     in_word.permittivity_in};
    end
    stat_q <= stat_mem[raddr];
  end

  // Stencil pipeline. Tag 0 is the center cell, tags 1 to 6 its neighbors.
  // Stage 1 is the registered memory read, stage 2 the dielectric product, stage 3 the
  // weighted potential, stage 4 the flux product; the flux sum is kept behind stage 4.
  logic                     v1, v2, v3, v4;
  logic [2:0]               t1, t2, t3, t4;
  logic signed [DATA_W-1:0] phi2, phi3, w3, wc, phi_c;
  logic signed [56:0]       prod2;
  logic signed [64:0]       prodt4;
  logic signed [34:0]       flux_acc;
  logic signed [DATA_W-1:0] chg_c, ind_c;
  logic [EPS_W-1:0]         eps_c;

  logic signed [64:0]       w_full, term_full;
  logic signed [DATA_W-1:0] w_sat, term;
  logic signed [32:0]       diff;
  logic [COEF_W-1:0]        coef_sel;
  logic                     ev_w, ev_t;

  assign w_full    = 65'($signed(prod2 >>> FRAC_BITS));
  assign w_sat     = clamp(w_full);
  assign ev_w      = v2 && diel && over(w_full);
  assign diff      = 33'(wc) - 33'(w3);
  assign coef_sel  = (t3 <= 3'd2) ? coef_x : ((t3 <= 3'd4) ? coef_y : coef_z);
  assign term_full = prodt4 >>> FRAC_BITS;
  assign term      = clamp(term_full);
  assign ev_t      = v4 && (t4 != 3'd0) && over(term_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= issuing;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    t1     <= tag;
    t2     <= t1;
    t3     <= t2;
    t4     <= t3;
    phi2   <= $signed(pot_q);
    prod2  <= $signed(pot_q) * $signed({1'b0, stat_q.eps});
    w3     <= diel ? w_sat : phi2;
    phi3   <= phi2;
    prodt4 <= diff * $signed({1'b0, coef_sel});
    if (v1 && (t1 == 3'd0)) begin
      chg_c <= stat_q.charge;
      ind_c <= stat_q.induced;
      eps_c <= stat_q.eps;
    end
    if (v3 && (t3 == 3'd0)) begin
      wc    <= w3;
      phi_c <= phi3;
    end
    if (issuing && (tag == 3'd0)) begin
      flux_acc <= '0;
    end else if (v4 && (t4 != 3'd0)) begin
      flux_acc <= flux_acc + 35'(term);
    end
  end

  // Cell finish: scale the flux, form the residual, optionally divide, update.
  logic signed [63:0]       prods;
  logic signed [DATA_W-1:0] d_reg;
  logic signed [64:0]       flux_full, s_full, d_full, nphi_full;
  logic signed [DATA_W-1:0] fluxs, s_val, d_comb;
  logic signed [32:0]       dx;
  logic [32:0]              mag;
  logic [RES_W-1:0]         res_abs, peak_next;
  logic                     ev_flux, ev_s, ev_d, ev_div, ev_u;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  assign flux_full = 65'(flux_acc);
  assign fluxs     = clamp(flux_full);
  assign ev_flux   = (state == S_FLUX) && over(flux_full);
  assign s_full    = 65'($signed(prods >>> FRAC_BITS));
  assign s_val     = clamp(s_full);
  assign ev_s      = (state == S_RESID) && over(s_full);
  assign d_full    = 65'(chg_c) - 65'(s_val) + (ind ? 65'(ind_c) : 65'sd0);
  assign d_comb    = clamp(d_full);
  assign ev_d      = (state == S_RESID) && over(d_full);
  assign ev_div    = (state == S_DIV) && div_rsp.done && div_rsp.ovf;
  assign nphi_full = 65'(phi_c) + 65'(d_reg >>> 1);
  assign nphi      = clamp(nphi_full);
  assign ev_u      = upd_we && over(nphi_full);

  // The reported residual magnitude is clamped without raising the flag.
  assign dx        = 33'(d_reg);
  assign mag       = dx[32] ? 33'(-dx) : 33'(dx);
  assign res_abs   = (mag > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : mag[RES_W-1:0];
  assign peak_next = (res_abs > peak) ? res_abs : peak;

  assign div_req.start = (state == S_RESID) && diel;
  assign div_req.d     = d_comb;
  assign div_req.eps   = eps_c;

  psr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (state == S_FLUX) begin
      prods <= fluxs * $signed({1'b0, flux_scale});
    end
  end

  // Scan position for the next interior cell.
  logic row_end, col_end, plane_end;
  assign row_end   = (xi == nx_r - 6'd2);
  assign col_end   = (yj == ny_r - 6'd2);
  assign plane_end = (zk == nz_r - 6'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      inflight <= 1'b0;
      ovf      <= 1'b0;
      peak     <= '0;
      res_peak <= '0;
    end else begin
      inflight <= read_acc;
      // A new run starts with a clear flag; otherwise every saturation event is collected.
      ovf      <= ((state == S_IDLE) && run_acc) ? 1'b0 :
                  (ovf | ev_w | ev_t | ev_flux | ev_s | ev_d | ev_div | ev_u);
      case (state)
        S_IDLE: begin
          if (run_acc) begin
            peak        <= '0;
            res_peak    <= '0;
            nx_r        <= nx_a;
            ny_r        <= ny_a;
            nz_r        <= nz_a;
            nxy_r       <= ADDR_W'(nxy_a);
            c           <= ADDR_W'(nxy_a) + ADDR_W'(nx_a) + ADDR_W'(1);
            c_start     <= ADDR_W'(nxy_a) + ADDR_W'(nx_a) + ADDR_W'(1);
            xi          <= 6'd1;
            yj          <= 6'd1;
            zk          <= 6'd1;
            tag         <= 3'd0;
            sweeps_left <= in_word.sweep_count;
            if ((in_word.sweep_count == '0) || small_a) begin
              state <= S_DONE;
            end else begin
              state <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          tag <= tag + 3'd1;
          if (tag == TAG_LAST) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (v4 && (t4 == TAG_LAST)) begin
            state <= S_FLUX;
          end
        end
        S_FLUX: begin
          state <= S_RESID;
        end
        S_RESID: begin
          d_reg <= d_comb;
          state <= diel ? S_DIV : S_UPDATE;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            d_reg <= div_rsp.q;
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          tag   <= 3'd0;
          state <= S_ISSUE;
          if (!row_end) begin
            peak <= peak_next;
            c    <= c + ADDR_W'(1);
            xi   <= xi + 6'd1;
          end else if (!col_end) begin
            peak <= peak_next;
            c    <= c + ADDR_W'(3);
            xi   <= 6'd1;
            yj   <= yj + 6'd1;
          end else if (!plane_end) begin
            peak <= peak_next;
            c    <= c + ADDR_W'(3) + ADDR_W'({nx_r, 1'b0});
            xi   <= 6'd1;
            yj   <= 6'd1;
            zk   <= zk + 6'd1;
          end else begin
            // Last cell of a sweep: its peak is the run's answer so far.
            res_peak    <= peak_next;
            peak        <= '0;
            c           <= c_start;
            xi          <= 6'd1;
            yj          <= 6'd1;
            zk          <= 6'd1;
            sweeps_left <= sweeps_left - 12'd1;
            if (sweeps_left == 12'd1) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result queue: out_word is the head, tail holds a second word.
  assign push = inflight || (state == S_DONE);

  always_comb begin
    if (inflight) begin
      push_word = '{potential_out: $signed(pot_q), residual_max: '0, saturated: 1'b0};
    end else begin
      push_word = '{potential_out: '0, residual_max: res_peak, saturated: ovf};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_cnt <= 2'd0;
    end else begin
      fifo_cnt <= fifo_cnt + 2'(push) - 2'(pop);
    end
    if (push && ((fifo_cnt == 2'd0) || ((fifo_cnt == 2'd1) && pop))) begin
      out_word <= push_word;
    end else if (pop && (fifo_cnt == 2'd2)) begin
      out_word <= tail;
    end
    if (push && (((fifo_cnt == 2'd1) && !pop) || ((fifo_cnt == 2'd2) && pop))) begin
      tail <= push_word;
    end
  end

  // The queue never overflows: a slot is reserved when a read or a run is accepted.
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (fifo_cnt != 2'd2))
    else $error("result queue overflow");

  // A potential write-back never overlaps stencil reads still in flight.
  a_write_interlock: assert property (@(posedge clk) disable iff (rst)
    upd_we |-> !(v1 || v2 || v3 || v4))
    else $error("write-back while stencil reads in flight");

  // The divider only runs with dielectric weighting and finishes before the update.
  a_div_mode: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> (diel && (state == S_RESID)) ##1 (state == S_DIV))
    else $error("divider started outside the dielectric path");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench of the Poisson stencil relaxation unit, with its own grid predictor.
module testbench;
  import psr_pkg::*;

  // Idling patterns that rotate from phase to phase.
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  // One row of the directed table. When pinned is set, the result is typed in
  // and replaces the prediction; the grid model is still stepped so that it stays current.
  typedef struct {
    in_word_t  w;
    bit        pinned;
    out_word_t want;
  } stim_row_t;

  localparam int CELLS       = 32768;
  localparam int WATCH_LIMIT = 400000;
  localparam int SETTLE      = 30;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  in_word_t             in_word;
  logic                 out_valid;
  logic                 out_stall;
  out_word_t            out_word;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_data;

  poisson_stencil_relaxation_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Grid model: the four cell stores and the register copies.
  longint      grid_pot [CELLS];
  longint      grid_chg [CELLS];
  longint      grid_ind [CELLS];
  longint      grid_eps [CELLS];
  bit          loaded   [CELLS];
  int          loaded_far[$];
  int          dim_x, dim_y, dim_z;
  longint      wt_x, wt_y, wt_z, wt_scale;
  logic [1:0]  cur_mode;
  bit          clamp_hit;

  out_word_t   pending_results[$];
  idle_mode_t  idle_mode;
  int          hold_req;
  int          errors;
  stim_row_t   directed[$];

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Clamp to the signed 32-bit range and remember that it happened.
  function automatic longint clamp32(longint v);
    if (v > longint'(DMAX)) begin
      clamp_hit = 1'b1;
      return longint'(DMAX);
    end
    if (v < longint'(DMIN)) begin
      clamp_hit = 1'b1;
      return longint'(DMIN);
    end
    return v;
  endfunction

  function automatic longint weighted_pot(int c, bit diel);
    if (!diel) return grid_pot[c];
    return clamp32((grid_pot[c] * grid_eps[c]) >>> FRAC_BITS);
  endfunction

  function automatic longint flux_term(longint wc, longint wn, longint coef);
    return clamp32(((wc - wn) * coef) >>> FRAC_BITS);
  endfunction

  // One in-place sweep over the interior; returns the peak absolute residual.
  function automatic longint relax_sweep();
    bit     diel;
    bit     ind;
    int     nxy;
    int     c;
    longint peak;
    longint wc;
    longint flux;
    longint s;
    longint d;
    longint a;
    diel = cur_mode[MODE_DIEL];
    ind  = cur_mode[MODE_IND];
    nxy  = dim_x * dim_y;
    peak = 0;
    for (int k = 1; k + 1 < dim_z; k++)
      for (int j = 1; j + 1 < dim_y; j++)
        for (int i = 1; i + 1 < dim_x; i++) begin
          c    = (k * dim_y + j) * dim_x + i;
          wc   = weighted_pot(c, diel);
          flux = flux_term(wc, weighted_pot(c - 1, diel), wt_x);
          flux += flux_term(wc, weighted_pot(c + 1, diel), wt_x);
          flux += flux_term(wc, weighted_pot(c - dim_x, diel), wt_y);
          flux += flux_term(wc, weighted_pot(c + dim_x, diel), wt_y);
          flux += flux_term(wc, weighted_pot(c - nxy, diel), wt_z);
          flux += flux_term(wc, weighted_pot(c + nxy, diel), wt_z);
          flux = clamp32(flux);
          s    = clamp32((flux * wt_scale) >>> FRAC_BITS);
          d    = grid_chg[c] - s;
          if (ind) d += grid_ind[c];
          d = clamp32(d);
          if (diel) begin
            // A zero dielectric pins a nonzero residual at the rail of its sign.
            if (grid_eps[c] == 0) begin
              if (d > 0) d = clamp32(longint'(DMAX) + 1);
              else if (d < 0) d = clamp32(longint'(DMIN) - 1);
            end else begin
              d = clamp32((d * (longint'(1) << FRAC_BITS)) / grid_eps[c]);
            end
          end
          a = (d < 0) ? -d : d;
          if (a > 64'sh7FFF_FFFF) a = 64'sh7FFF_FFFF;
          if (a > peak) peak = a;
          grid_pot[c] = clamp32(grid_pot[c] + (d >>> 1));
        end
    return peak;
  endfunction

  // Steps the grid model by one word; has_result tells whether a result is due.
  function automatic void predict_word(in_word_t w, output bit has_result, output out_word_t r);
    int     idx;
    longint peak;
    idx        = int'(w.cell_index);
    has_result = 1'b0;
    r          = '0;
    case (w.action)
      ACT_LOAD: begin
        grid_chg[idx] = longint'(w.charge_in);
        grid_ind[idx] = longint'(w.induced_in);
        grid_eps[idx] = longint'({40'd0, w.permittivity_in});
        grid_pot[idx] = longint'(w.potential_in);
        loaded[idx]   = 1'b1;
      end
      ACT_RUN: begin
        clamp_hit = 1'b0;
        peak      = 0;
        for (int s = 0; s < int'(w.sweep_count); s++) peak = relax_sweep();
        r.residual_max = peak[RES_W-1:0];
        r.saturated    = clamp_hit;
        has_result     = 1'b1;
      end
      ACT_READ: begin
        r.potential_out = grid_pot[idx][DATA_W-1:0];
        has_result      = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic int stall_percent(bit sender);
    if (idle_mode == IDLE_BOTH) return 15;
    if (sender && idle_mode == IDLE_SEND) return 72;
    if (!sender && idle_mode == IDLE_RECV) return 72;
    return 0;
  endfunction

  // Offers one word and returns at the edge that accepts it. Entry is always at a rising
  // edge, and valid is lowered only when a random gap comes before the word.
  task automatic send_word(in_word_t w, bit pinned, out_word_t want);
    int        gap;
    bit        taken;
    bit        has_result;
    out_word_t r;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < stall_percent(1'b1)) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    predict_word(w, has_result, r);
    if (has_result) pending_results.push_back(pinned ? want : r);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_SIZE_X:     dim_x = (val[5:0] > MAX_DIM) ? int'(MAX_DIM) : int'(val[5:0]);
      REG_SIZE_Y:     dim_y = (val[5:0] > MAX_DIM) ? int'(MAX_DIM) : int'(val[5:0]);
      REG_SIZE_Z:     dim_z = (val[5:0] > MAX_DIM) ? int'(MAX_DIM) : int'(val[5:0]);
      REG_COEF_X:     wt_x = longint'({33'd0, val});
      REG_COEF_Y:     wt_y = longint'({33'd0, val});
      REG_COEF_Z:     wt_z = longint'({33'd0, val});
      REG_FLUX_SCALE: wt_scale = longint'({33'd0, val});
      default:        cur_mode = val[1:0];
    endcase
  endtask

  // Holds the sender off until every result has arrived, then lets the unit settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Moderate values or zero in half the draws, so that runs do not simply pin everything at the rails.
  function automatic logic [DATA_W-1:0] rand_data();
    case ($urandom_range(5))
      0:       return $urandom;
      1:       return DMAX;
      2:       return DMIN;
      3:       return '0;
      default: return DATA_W'($signed($urandom_range(1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic logic [EPS_W-1:0] rand_eps();
    if ($urandom_range(2) == 0) return EPS_W'($urandom_range(16777215, 65536));
    return EPS_W'($urandom_range(196608, 65536));
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(4))
      0:       return '0;
      1:       return COEF_W'(32'h7FFF_FFFF);
      2:       return COEF_W'($urandom);
      default: return COEF_W'($urandom_range(131072, 0));
    endcase
  endfunction

  function automatic in_word_t load_word(int idx, bit blank);
    in_word_t w;
    w.action          = ACT_LOAD;
    w.cell_index      = ADDR_W'(idx);
    w.charge_in       = blank ? '0 : rand_data();
    w.induced_in      = blank ? '0 : rand_data();
    w.permittivity_in = blank ? EPS_W'(65536) : rand_eps();
    w.potential_in    = blank ? '0 : rand_data();
    w.sweep_count     = SWEEP_W'($urandom);
    return w;
  endfunction

  // Every cell of the grid is loaded before any run touches it.
  task automatic fill_grid(bit blank);
    for (int i = 0; i < dim_x * dim_y * dim_z; i++) send_word(load_word(i, blank), 1'b0, '0);
  endtask

  function automatic void add_row(logic [1:0] act, int idx, logic [DATA_W-1:0] chg,
                                  logic [DATA_W-1:0] pot, int sweeps, bit pinned,
                                  out_word_t want);
    stim_row_t row;
    row.w                 = '0;
    row.w.action          = act;
    row.w.cell_index      = ADDR_W'(idx);
    row.w.charge_in       = chg;
    row.w.induced_in      = ~chg;
    row.w.permittivity_in = (act == ACT_LOAD) ? EPS_W'(16777215) : EPS_W'(65536);
    row.w.potential_in    = pot;
    row.w.sweep_count     = SWEEP_W'(sweeps);
    row.pinned            = pinned;
    row.want              = want;
    directed.push_back(row);
  endfunction

  function automatic out_word_t read_result(logic [DATA_W-1:0] pot);
    out_word_t r;
    r               = '0;
    r.potential_out = pot;
    return r;
  endfunction

  // Receiver: random stalls by phase, plus a long hold-off counted here.
  always @(posedge clk) begin
    static int hold_left = 0;
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_percent(1'b0));
    end
  end

  // Result checking and the watchdog. Both sample at the falling edge, where every
  // signal is settled and reflects what the next rising edge will see.
  always @(negedge clk) begin
    static int quiet = 0;
    out_word_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        quiet = 0;
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected: %h", out_word);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_word.potential_out !== want.potential_out) begin
            $error("potential_out: expected %h, got %h", want.potential_out,
                   out_word.potential_out);
            errors++;
          end
          if (out_word.residual_max !== want.residual_max) begin
            $error("residual_max: expected %h, got %h", want.residual_max,
                   out_word.residual_max);
            errors++;
          end
          if (out_word.saturated !== want.saturated) begin
            $error("saturated: expected %b, got %b", want.saturated, out_word.saturated);
            errors++;
          end
        end
      end else if (in_valid && !in_stall) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= WATCH_LIMIT) begin
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  initial begin
    in_word_t w;
    int       pick;
    int       far_idx;
    errors    = 0;
    hold_req  = 0;
    idle_mode = IDLE_NONE;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_word   = '0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    dim_x     = 32;
    dim_y     = 32;
    dim_z     = 32;
    wt_x      = 65536;
    wt_y      = 65536;
    wt_z      = 65536;
    wt_scale  = 869;
    cur_mode  = 2'd0;
    for (int i = 0; i < CELLS; i++) loaded[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on the smallest grid, which has a single interior cell at index 13.
    write_reg(REG_SIZE_X, 3);
    write_reg(REG_SIZE_Y, 3);
    write_reg(REG_SIZE_Z, 3);
    write_reg(REG_MODE, 0);
    cfg_we <= 1'b0;
    fill_grid(1'b1);
    // A grid at rest relaxes to nothing.
    add_row(ACT_RUN, 0, '0, '0, 1, 1'b1, '0);
    add_row(ACT_LOAD, 13, DMAX, DMIN, 0, 1'b0, '0);
    add_row(ACT_READ, 13, '0, '0, 0, 1'b1, read_result(DMIN));
    add_row(ACT_RUN, 13, '0, '0, 1, 1'b0, '0);
    add_row(ACT_READ, 13, '0, '0, 0, 1'b0, '0);
    add_row(ACT_LOAD, 0, DMIN, DMAX, 0, 1'b0, '0);
    add_row(ACT_READ, 0, '0, '0, 0, 1'b1, read_result(DMAX));
    add_row(ACT_LOAD, 32767, '0, 32'h1234_5678, 4095, 1'b0, '0);
    add_row(ACT_READ, 32767, '0, '0, 0, 1'b1, read_result(32'h1234_5678));
    // An unknown action leaves the cell alone and yields nothing.
    add_row(ACT_UNUSED, 32767, DMAX, '0, 0, 1'b0, '0);
    add_row(ACT_READ, 32767, '0, '0, 0, 1'b1, read_result(32'h1234_5678));
    add_row(ACT_RUN, 0, '0, '0, 4095, 1'b0, '0);
    add_row(ACT_READ, 13, '0, '0, 0, 1'b0, '0);
    // Border cells are never updated by a run.
    add_row(ACT_READ, 0, '0, '0, 0, 1'b1, read_result(DMAX));
    foreach (directed[i]) send_word(directed[i].w, directed[i].pinned, directed[i].want);

    // Random phases, each with fresh registers on a freshly loaded grid.
    for (int p = 0; p < 13; p++) begin
      drain();
      idle_mode = idle_mode_t'((p + p / 4) % 4);
      case (p)
        4: begin
          write_reg(REG_SIZE_X, 32);
          write_reg(REG_SIZE_Y, 3);
          write_reg(REG_SIZE_Z, 3);
        end
        7: begin
          write_reg(REG_SIZE_X, 3);
          write_reg(REG_SIZE_Y, 32);
          write_reg(REG_SIZE_Z, 3);
        end
        10: begin
          write_reg(REG_SIZE_X, 3);
          write_reg(REG_SIZE_Y, 3);
          write_reg(REG_SIZE_Z, 32);
        end
        default: begin
          write_reg(REG_SIZE_X, COEF_W'($urandom_range(5, 3)));
          write_reg(REG_SIZE_Y, COEF_W'($urandom_range(5, 3)));
          write_reg(REG_SIZE_Z, COEF_W'($urandom_range(4, 3)));
        end
      endcase
      write_reg(REG_COEF_X, (p == 2) ? COEF_W'(0) : rand_coef());
      write_reg(REG_COEF_Y, (p == 3) ? COEF_W'(32'h7FFF_FFFF) : rand_coef());
      write_reg(REG_COEF_Z, rand_coef());
      write_reg(REG_FLUX_SCALE, (p == 5) ? COEF_W'(32'h7FFF_FFFF) :
                                (p == 6) ? COEF_W'(0) : rand_coef());
      write_reg(REG_MODE, COEF_W'(p % 4));
      cfg_we <= 1'b0;
      fill_grid(1'b0);
      // In one phase the receiver holds off long enough for the unit to fill up and
      // stall its input while words keep being offered.
      if (p == 1) hold_req = 400;
      for (int n = 0; n < 90; n++) begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          if ($urandom_range(2) == 0) begin
            far_idx = $urandom_range(CELLS - 1);
            if (far_idx >= dim_x * dim_y * dim_z) loaded_far.push_back(far_idx);
          end else begin
            far_idx = $urandom_range(dim_x * dim_y * dim_z - 1);
          end
          w = load_word(far_idx, 1'b0);
        end else if (pick < 75) begin
          w = load_word(0, 1'b0);
          w.action = ACT_READ;
          if (loaded_far.size() > 0 && $urandom_range(3) == 0)
            w.cell_index = ADDR_W'(loaded_far[$urandom_range(loaded_far.size() - 1)]);
          else
            w.cell_index = ADDR_W'($urandom_range(dim_x * dim_y * dim_z - 1));
        end else if (pick < 95) begin
          w = load_word(0, 1'b0);
          w.action      = ACT_RUN;
          w.cell_index  = ADDR_W'($urandom);
          w.sweep_count = SWEEP_W'($urandom_range(3, 1));
          // Long grids get a single sweep to keep runs short.
          if (dim_x * dim_y * dim_z > 125) w.sweep_count = SWEEP_W'(1);
        end else begin
          w = load_word($urandom_range(CELLS - 1), 1'b0);
          w.action = ACT_UNUSED;
        end
        send_word(w, 1'b0, '0);
      end
    end

    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
